[design/b64c_pkg.sv]
`default_nettype none

package b64c_pkg;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       DIR_DECODE = 1'b1;
    localparam logic [7:0] PAD_CHAR   = 8'h3d;
    localparam logic [2:0] ADDR_DIRECTION = 3'd0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       bad_padding;
    } result_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = 8'h2b;
        else
            c = 8'h2f;
        return c;
    endfunction

    // alphabet character to {valid, 6-bit value}
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5a)
            r = {1'b1, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7a)
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2b)
            r = {1'b1, 6'd62};
        else if (c == 8'h2f)
            r = {1'b1, 6'd63};
        else
            r = 7'd0;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/base64_codec.sv]
// The first result of an accepted item appears on the master side in the next cycle.
// Throughput: one result per cycle while m_tready is high; an item is taken in the cycle
//   its last pending result leaves, or while none is pending. Encode emits up to four
//   results per byte (at flush) and decode at most one per character, into the 4-entry result buffer.
// Reset (rst_n low, asynchronous): result buffer empty, group state cleared,
//   direction set to encode.
`default_nettype none

module base64_codec
    import b64c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_message
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [0] has_data, [1] bad_padding
    output logic             m_tlast    // out_last
);

    logic       direction_reg;
    logic [1:0] group_pos_reg;
    logic [7:0] partial_reg;
    logic       discard_reg;

    result_t    buf_reg [4];
    logic [2:0] rem_reg;
    logic [1:0] head_reg;
    logic       last_reg;

    result_t    res_next [4];
    logic [2:0] count_next;
    logic [1:0] group_pos_next;
    logic [7:0] partial_next;
    logic       discard_next;

    logic       in_fire;
    logic       out_fire;
    logic       cfg_write;
    logic [1:0] enc_pos;
    logic [6:0] sym;

    assign pready    = 1'b1;
    assign prdata    = {31'd0, direction_reg};
    assign cfg_write = psel && penable && pwrite && pready;

    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = buf_reg[head_reg].out_byte;
    assign m_tuser  = {buf_reg[head_reg].bad_padding, buf_reg[head_reg].has_data};
    assign m_tlast  = last_reg && (rem_reg == 3'd1);

    // take a new item while the last pending result leaves, or when none is pending
    assign s_tready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    assign enc_pos = (group_pos_reg == 2'd3) ? 2'd0 : group_pos_reg;
    assign sym     = dec_char(s_tdata);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            res_next[i] = '0;
        end
        count_next     = 3'd0;
        group_pos_next = group_pos_reg;
        partial_next   = partial_reg;
        discard_next   = discard_reg;

        if (discard_reg)
        begin
            // drop
        end
        else if (direction_reg == DIR_ENCODE)
        begin
            case (enc_pos)
                2'd0:
                begin
                    res_next[0]    = '{enc_char(s_tdata[7:2]), 1'b1, 1'b0};
                    partial_next   = {6'd0, s_tdata[1:0]};
                    group_pos_next = 2'd1;
                    count_next     = 3'd1;
                    if (s_tlast)
                    begin
                        res_next[1] = '{enc_char({s_tdata[1:0], 4'd0}), 1'b1, 1'b0};
                        res_next[2] = '{PAD_CHAR, 1'b1, 1'b0};
                        res_next[3] = '{PAD_CHAR, 1'b1, 1'b0};
                        count_next  = 3'd4;
                    end
                end
                2'd1:
                begin
                    res_next[0]    = '{enc_char({partial_reg[1:0], s_tdata[7:4]}), 1'b1, 1'b0};
                    partial_next   = {4'd0, s_tdata[3:0]};
                    group_pos_next = 2'd2;
                    count_next     = 3'd1;
                    if (s_tlast)
                    begin
                        res_next[1] = '{enc_char({s_tdata[3:0], 2'd0}), 1'b1, 1'b0};
                        res_next[2] = '{PAD_CHAR, 1'b1, 1'b0};
                        count_next  = 3'd3;
                    end
                end
                default:
                begin
                    res_next[0]    = '{enc_char({partial_reg[3:0], s_tdata[7:6]}), 1'b1, 1'b0};
                    res_next[1]    = '{enc_char(s_tdata[5:0]), 1'b1, 1'b0};
                    partial_next   = 8'd0;
                    group_pos_next = 2'd0;
                    count_next     = 3'd2;
                end
            endcase
        end
        else
        begin
            if (s_tdata == PAD_CHAR)
            begin
                // padding right after the first symbol of a quartet aborts the message
                if (group_pos_reg == 2'd1)
                begin
                    res_next[0]  = '{8'd0, 1'b0, 1'b1};
                    count_next   = 3'd1;
                    discard_next = 1'b1;
                end
            end
            else if (sym[6])
            begin
                case (group_pos_reg)
                    2'd0:
                    begin
                        partial_next = {sym[5:0], 2'd0};
                    end
                    2'd1:
                    begin
                        res_next[0]  = '{partial_reg | {6'd0, sym[5:4]}, 1'b1, 1'b0};
                        partial_next = {sym[3:0], 4'd0};
                        count_next   = 3'd1;
                    end
                    2'd2:
                    begin
                        res_next[0]  = '{partial_reg | {2'd0, sym[5:0] >> 2}, 1'b1, 1'b0};
                        partial_next = {sym[1:0], 6'd0};
                        count_next   = 3'd1;
                    end
                    default:
                    begin
                        res_next[0]  = '{partial_reg | {2'd0, sym[5:0]}, 1'b1, 1'b0};
                        partial_next = 8'd0;
                        count_next   = 3'd1;
                    end
                endcase
                group_pos_next = group_pos_reg + 2'd1;
            end
        end

        if (s_tlast)
        begin
            // entry 0 already holds zeros: a bare end marker
            if (count_next == 3'd0)
            begin
                count_next = 3'd1;
            end
            group_pos_next = 2'd0;
            partial_next   = 8'd0;
            discard_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            group_pos_reg <= 2'd0;
            partial_reg   <= 8'd0;
            discard_reg   <= 1'b0;
            rem_reg       <= 3'd0;
            head_reg      <= 2'd0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr == ADDR_DIRECTION))
            begin
                direction_reg <= pwdata[0];
            end
            if (in_fire)
            begin
                group_pos_reg <= group_pos_next;
                partial_reg   <= partial_next;
                discard_reg   <= discard_next;
                rem_reg       <= count_next;
                head_reg      <= 2'd0;
                last_reg      <= s_tlast;
            end
            else if (out_fire)
            begin
                rem_reg  <= rem_reg - 3'd1;
                head_reg <= head_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 4; i++)
            begin
                buf_reg[i] <= res_next[i];
            end
        end
    end

endmodule

`default_nettype wire

[design/b64c_checker.sv]
`default_nettype none

module b64c_checker
    import b64c_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // an error item never carries data
    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("bad_padding item carries data");

    // a bare marker appears only at the end of a message
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tlast)
        else $error("bare item without last");

    // input stalls only while results are pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind base64_codec b64c_checker u_b64c_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/b64c_checker.sv]
`default_nettype none

module tb_b64c_checker
    import b64c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_message
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] out_byte
    input  wire logic [1:0]  m_tuser,   // [0] has_data, [1] bad_padding
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               pending
);

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] value;
        logic       has_data;
        logic       last;
        logic       bad_pad;
    } codec_out_t;

    codec_out_t  codec_out_q[$];
    logic [1:0]  grp_pos  = 2'd0;
    logic [7:0]  held     = 8'd0;
    logic        dropping = 1'b0;
    logic        dir_mode = DIR_ENCODE;
    int          fails    = 0;
    int          queued   = 0;

    assign mismatches = fails;
    assign pending    = queued;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    // -1 for anything outside the alphabet
    function automatic int symbol_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0") + 52;
        if (c == "+")
            return 62;
        if (c == "/")
            return 63;
        return -1;
    endfunction

    function automatic void add_out(input logic [7:0] v, input logic has, input logic bad);
        codec_out_q.push_back('{v, has, 1'b0, bad});
    endfunction

    task automatic codec_step(input logic [7:0] ch, input logic eom);
        int          before_n;
        int          sym;
        logic [5:0]  sv;
        logic [1:0]  pos;
        codec_out_t  tail;
        before_n = codec_out_q.size();
        if (dropping) begin
        end
        else if (dir_mode == DIR_ENCODE) begin
            // position 3 is left over from decoding: start a new group
            pos = (grp_pos == 2'd3) ? 2'd0 : grp_pos;
            case (pos)
                2'd0: begin
                    add_out(b64_char(ch[7:2]), 1'b1, 1'b0);
                    held    = {6'd0, ch[1:0]};
                    grp_pos = 2'd1;
                end
                2'd1: begin
                    add_out(b64_char({held[1:0], ch[7:4]}), 1'b1, 1'b0);
                    held    = {4'd0, ch[3:0]};
                    grp_pos = 2'd2;
                end
                default: begin
                    add_out(b64_char({held[3:0], ch[7:6]}), 1'b1, 1'b0);
                    add_out(b64_char(ch[5:0]), 1'b1, 1'b0);
                    held    = 8'd0;
                    grp_pos = 2'd0;
                end
            endcase
            if (eom) begin
                if (grp_pos == 2'd1) begin
                    add_out(b64_char({held[1:0], 4'd0}), 1'b1, 1'b0);
                    add_out(PAD_CHAR, 1'b1, 1'b0);
                    add_out(PAD_CHAR, 1'b1, 1'b0);
                end
                else if (grp_pos == 2'd2) begin
                    add_out(b64_char({held[3:0], 2'd0}), 1'b1, 1'b0);
                    add_out(PAD_CHAR, 1'b1, 1'b0);
                end
            end
        end
        else begin
            sym = symbol_of(ch);
            sv  = sym[5:0];
            if (ch == PAD_CHAR) begin
                if (grp_pos == 2'd1) begin
                    add_out(8'd0, 1'b0, 1'b1);
                    dropping = 1'b1;
                end
            end
            else if (sym >= 0) begin
                case (grp_pos)
                    2'd0: held = {sv, 2'd0};
                    2'd1: begin
                        add_out(held | {6'd0, sv[5:4]}, 1'b1, 1'b0);
                        held = {sv[3:0], 4'd0};
                    end
                    2'd2: begin
                        add_out(held | {4'd0, sv[5:2]}, 1'b1, 1'b0);
                        held = {sv[1:0], 6'd0};
                    end
                    default: begin
                        add_out(held | {2'd0, sv}, 1'b1, 1'b0);
                        held = 8'd0;
                    end
                endcase
                grp_pos = grp_pos + 2'd1;
            end
        end
        if (eom) begin
            if (codec_out_q.size() == before_n)
                add_out(8'd0, 1'b0, 1'b0);
            tail      = codec_out_q.pop_back();
            tail.last = 1'b1;
            codec_out_q.push_back(tail);
            grp_pos  = 2'd0;
            held     = 8'd0;
            dropping = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        codec_out_t want;
        codec_out_t got;
        if (!rst_n) begin
            codec_out_q.delete();
            grp_pos  = 2'd0;
            held     = 8'd0;
            dropping = 1'b0;
            dir_mode = DIR_ENCODE;
            queued  <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION)
                dir_mode = pwdata[0];
            if (s_tvalid && s_tready)
                codec_step(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
                if (codec_out_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: unexpected item byte=%h has_data=%b last=%b bad=%b",
                                 got.value, got.has_data, got.last, got.bad_pad);
                end
                else begin
                    want = codec_out_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected byte=%h has_data=%b last=%b bad=%b",
                                     want.value, want.has_data, want.last, want.bad_pad);
                            $display("          got      byte=%h has_data=%b last=%b bad=%b",
                                     got.value, got.has_data, got.last, got.bad_pad);
                        end
                    end
                end
            end
            queued <= codec_out_q.size();
        end
    end

endmodule

`default_nettype wire

[dv/tb_base64_codec.sv]
`default_nettype none

module tb_base64_codec
    import b64c_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;   // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic [1:0]  m_tuser;           // [0] has_data, [1] bad_padding
    logic        m_tlast;
    int          mismatches;
    int          pending;
    int          sent = 0;

    always #5 clk = ~clk;

    base64_codec dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    tb_b64c_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mismatches(mismatches),
        .pending   (pending)
    );

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_item(input logic [7:0] b, input logic eom);
        int gap;
        // every fourth stretch of items goes back to back
        gap = ((sent / 48) % 4 == 2) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic push_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], close && i == s.len() - 1);
    endtask

    // drop valid, let every expected result arrive, then allow the block to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        wait_idle();
        reg_write(ADDR_DIRECTION, {31'd0, d});
    endtask

    function automatic logic [7:0] rand_symbol();
        return enc_char(6'($urandom_range(0, 63)));
    endfunction

    task automatic push_seq(input logic [7:0] txt[$], output int n);
        n = 0;
        for (int i = 0; i < txt.size(); i++) begin
            if ($urandom_range(0, 11) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0);
                n++;
            end
            push_item(txt[i], i == txt.size() - 1);
            n++;
        end
    endtask

    task automatic encode_msg(output int n);
        logic [7:0] txt[$];
        int         len;
        len = $urandom_range(1, 7);
        repeat (len) txt.push_back(8'($urandom_range(0, 255)));
        push_seq(txt, n);
    endtask

    task automatic decode_msg(output int n);
        logic [7:0] txt[$];
        int         quads;
        int         tail;
        quads = $urandom_range(0, 3);
        tail  = $urandom_range(0, 9);
        repeat (quads) repeat (4) txt.push_back(rand_symbol());
        case (tail)
            5: begin
                repeat (2) txt.push_back(rand_symbol());
                repeat (2) txt.push_back(PAD_CHAR);
            end
            6: begin
                repeat (3) txt.push_back(rand_symbol());
                txt.push_back(PAD_CHAR);
            end
            7: begin
                // pad right after a lone symbol, then more text to be dropped
                txt.push_back(rand_symbol());
                txt.push_back(PAD_CHAR);
                repeat ($urandom_range(0, 3)) txt.push_back(rand_symbol());
            end
            8: repeat ($urandom_range(1, 3)) txt.push_back(rand_symbol());
            default: ;
        endcase
        if (txt.size() == 0)
            txt.push_back(8'($urandom_range(0, 255)));
        push_seq(txt, n);
    endtask

    initial
    begin : receiver
        int stall;
        int taken;
        taken = 0;
        forever begin
            if (taken == 120 || taken == 280)
                stall = 150;
            else if ((taken / 32) % 4 == 3)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
        end
    end

    initial
    begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL base64_codec");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int count;
        int drain;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_write(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
        push_text("Man", 1'b1);
        push_item(8'h00, 1'b1);
        push_item(8'hff, 1'b0);
        push_item(8'hff, 1'b1);
        // leave a group half done and carry it over into decoding
        push_item(8'hff, 1'b0);
        push_item(8'h0f, 1'b0);
        set_direction(DIR_DECODE);
        push_text("A=", 1'b1);
        push_text("+/9a", 1'b1);
        push_text("QQ==", 1'b1);
        push_text("Q=", 1'b1);
        push_text("Q=Zg", 1'b1);
        push_text(" \n", 1'b1);
        // three symbols in, then back to encoding
        push_text("QUJ", 1'b0);
        set_direction(DIR_ENCODE);
        push_item(8'ha5, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            set_direction((ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE);
            count = 0;
            while (count < 33) begin
                if (ph % 2 == 0)
                    decode_msg(n);
                else
                    encode_msg(n);
                count += n;
            end
        end

        s_tvalid <= 1'b0;
        drain = 0;
        do begin
            @(posedge clk);
            drain++;
        end while (pending != 0 && drain < 5000);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS base64_codec");
        else
            $display("FAIL base64_codec");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/b64c_pkg.sv
design/base64_codec.sv
design/b64c_checker.sv
dv/b64c_checker.sv
dv/tb_base64_codec.sv
